### src/pmci_pkg.sv
// Package for the meander curve cell index block: widths, stage record,
// block selection and orientation tables. No dependencies.
`timescale 1ns / 1ps

package pmci_pkg;

    localparam int MAX_LEVEL_DEF = 8;
    localparam int LEVEL_W       = 4;
    localparam int COORD_W       = 13;
    localparam int POS_W         = 26;
    // wide enough for 2 * 3^11 and 3^12
    localparam int SIDE_W        = 20;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(3);

    // orientation code bits
    localparam logic [1:0] CODE_NONE = 2'b00;
    localparam logic [1:0] CODE_SWAP = 2'b01;
    localparam logic [1:0] CODE_COMP = 2'b10;
    localparam logic [1:0] CODE_BOTH = 2'b11;

    typedef logic [1:0] digit_t;
    typedef logic [3:0] block_t;

    typedef struct packed {
        logic                valid;
        logic                oor;
        logic [COORD_W-1:0]  row_rem;
        logic [COORD_W-1:0]  col_rem;
        logic [POS_W-1:0]    pos;
        logic [1:0]          code;
    } stage_t;

    function automatic int pow3(input int n);
        int r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 3;
        end
        return r;
    endfunction

    // block index from the transformed (row digit, col digit)
    function automatic block_t blk_of(input digit_t dr, input digit_t dc);
        block_t b;
        case ({dr, dc})
            4'b10_10: b = 4'd0;
            4'b10_01: b = 4'd1;
            4'b01_01: b = 4'd2;
            4'b01_10: b = 4'd3;
            4'b00_10: b = 4'd4;
            4'b00_01: b = 4'd5;
            4'b00_00: b = 4'd6;
            4'b01_00: b = 4'd7;
            4'b10_00: b = 4'd8;
            default:  b = 4'd0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] blk_code(input block_t b);
        logic [1:0] c;
        case (b) inside
            4'd1, 4'd2: c = CODE_SWAP;
            4'd3:       c = CODE_COMP;
            4'd7, 4'd8: c = CODE_BOTH;
            default:    c = CODE_NONE;
        endcase
        return c;
    endfunction

endpackage

### src/pmci_in_if.sv
// Input channel: cell coordinates with valid/ready handshake.
// Depends on pmci_pkg.
`timescale 1ns / 1ps

interface pmci_in_if;
    logic                        valid;
    logic                        ready;
    logic [pmci_pkg::COORD_W-1:0] cell_row;
    logic [pmci_pkg::COORD_W-1:0] cell_col;

    modport source (output valid, output cell_row, output cell_col, input ready);
    modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface

### src/pmci_out_if.sv
// Output channel: curve position and range flag with valid/ready handshake.
// Depends on pmci_pkg.
`timescale 1ns / 1ps

interface pmci_out_if;
    logic                       valid;
    logic                       ready;
    logic [pmci_pkg::POS_W-1:0] curve_position;
    logic                       out_of_range;

    modport source (output valid, output curve_position, output out_of_range, input ready);
    modport sink   (input valid, input curve_position, input out_of_range, output ready);
endinterface

### src/pmci_cell.sv
// One digit level of the curve index chain: extracts a base-3 digit pair,
// picks the block, updates position and orientation. Depends on pmci_pkg.
`timescale 1ns / 1ps

module pmci_cell #(
    parameter int DIGIT_POS = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic [pmci_pkg::LEVEL_W-1:0]     level,
    input  pmci_pkg::stage_t                 stage_in,
    output pmci_pkg::stage_t                 stage_out
);
    import pmci_pkg::*;

    localparam logic [SIDE_W-1:0] P1 = SIDE_W'(pow3(DIGIT_POS));
    localparam logic [SIDE_W-1:0] P2 = SIDE_W'(2 * pow3(DIGIT_POS));

    logic             valid_reg;
    stage_t           data_reg;
    stage_t           data_next;
    logic             active;
    digit_t           row_dig, col_dig;
    digit_t           dr, dc;
    logic [SIDE_W-1:0] row_w, col_w, row_sub, col_sub;
    block_t           blk;

    assign active = (SIDE_W'(DIGIT_POS) < SIDE_W'(level));
    assign row_w  = SIDE_W'(stage_in.row_rem);
    assign col_w  = SIDE_W'(stage_in.col_rem);

    always_comb
    begin
        if (row_w >= P2) begin
            row_dig = 2'd2;
            row_sub = P2;
        end else if (row_w >= P1) begin
            row_dig = 2'd1;
            row_sub = P1;
        end else begin
            row_dig = 2'd0;
            row_sub = '0;
        end
        if (col_w >= P2) begin
            col_dig = 2'd2;
            col_sub = P2;
        end else if (col_w >= P1) begin
            col_dig = 2'd1;
            col_sub = P1;
        end else begin
            col_dig = 2'd0;
            col_sub = '0;
        end

        dr = stage_in.code[0] ? col_dig : row_dig;
        dc = stage_in.code[0] ? row_dig : col_dig;
        if (stage_in.code[1]) begin
            dr = 2'd2 - dr;
            dc = 2'd2 - dc;
        end
        blk = blk_of(dr, dc);

        data_next         = stage_in;
        data_next.row_rem = COORD_W'(row_w - row_sub);
        data_next.col_rem = COORD_W'(col_w - col_sub);
        // levels above the configured depth leave position and code alone
        if (active) begin
            data_next.pos  = (stage_in.pos << 3) + stage_in.pos + POS_W'(blk);
            data_next.code = stage_in.code ^ blk_code(blk);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

### src/peano_meander_cell_index.sv
// Top level of the meander curve cell index: range check, chain of digit
// cells, output register. Depends on pmci_pkg, pmci_in_if, pmci_out_if, pmci_cell.
//
//  channel     dir  handshake      payload
//  cell_in     in   valid/ready    cell_row[12:0], cell_col[12:0]
//  curve_out   out  valid/ready    curve_position[25:0], out_of_range
//  cfg         in   cfg_wr_en      cfg_wr_data[3:0] (curve_level)
//
// One transaction per cycle unless the chain holds; each input passes the
// register of every digit cell and then the output register.
// The whole chain advances together; it holds only while the output
// register is full and curve_out.ready is low.
// Reset empties the chain and sets curve_level to 3.
`timescale 1ns / 1ps

module peano_meander_cell_index #(
    parameter int MAX_LEVEL = pmci_pkg::MAX_LEVEL_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pmci_pkg::LEVEL_W-1:0]  cfg_wr_data,
    pmci_in_if.sink                       cell_in,
    pmci_out_if.source                    curve_out
);
    import pmci_pkg::*;

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_eff;
    logic [SIDE_W-1:0]  side;
    logic               en;
    stage_t             chain [0:MAX_LEVEL];

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_reg <= LEVEL_RESET;
        end else if (cfg_wr_en) begin
            level_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        level_eff = level_reg;
        if (level_reg == '0) begin
            level_eff = LEVEL_W'(1);
        end else if (level_reg > LEVEL_W'(MAX_LEVEL)) begin
            level_eff = LEVEL_W'(MAX_LEVEL);
        end
        side = '0;
        for (int i = 1; i <= MAX_LEVEL; i++) begin
            if (level_eff == LEVEL_W'(i)) begin
                side = SIDE_W'(pow3(i));
            end
        end
    end

    assign en            = !out_valid_reg || curve_out.ready;
    assign cell_in.ready = en;

    always_comb
    begin
        chain[0].valid   = cell_in.valid;
        chain[0].oor     = (SIDE_W'(cell_in.cell_row) >= side)
                         || (SIDE_W'(cell_in.cell_col) >= side);
        chain[0].row_rem = cell_in.cell_row;
        chain[0].col_rem = cell_in.cell_col;
        chain[0].pos     = '0;
        chain[0].code    = CODE_NONE;
    end

    // cell k handles digit position MAX_LEVEL-1-k, top digit first
    for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_cell
        pmci_cell #(
            .DIGIT_POS (MAX_LEVEL - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .level     (level_eff),
            .stage_in  (chain[k]),
            .stage_out (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain[MAX_LEVEL].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_oor_reg <= chain[MAX_LEVEL].oor;
            out_pos_reg <= chain[MAX_LEVEL].oor ? '0 : chain[MAX_LEVEL].pos + POS_W'(1);
        end
    end

    assign curve_out.valid          = out_valid_reg;
    assign curve_out.curve_position = out_pos_reg;
    assign curve_out.out_of_range   = out_oor_reg;

endmodule
